@@ design/palette_snap_rgb565_unit_macros.svh @@
// Assertion macros used by the palette snap design.
`ifndef PALETTE_SNAP_RGB565_UNIT_MACROS_SVH
`define PALETTE_SNAP_RGB565_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PSR_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("palette snap check failed");

// Check that a condition is later followed by another.
`define PSR_ASSERT_LAT2(lbl, ante, cons) \
   `PSR_ASSERT(lbl, (ante) |-> ##2 (cons))

`endif

@@ design/pal_snap_pkg.sv @@
`timescale 1ns / 1ps

package pal_snap_pkg;

   // Palette geometry
   localparam int PALETTE_ENTRIES = 16;
   localparam int PAL_SLOTS       = 16;
   localparam int PAL_WORDS       = 4;
   localparam int COLOR_W         = 16;
   localparam int DIST_W          = 13;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 64;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PAL0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAL1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAL2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAL3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESH = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE = 3'd5;

   // Reset contents of the palette words, word 0 in the low bits
   localparam logic [PAL_WORDS-1:0][CSR_DATA_W-1:0] PAL_RESET = {
      64'd14283311077653974129,
      64'd6542564296988074724,
      64'd17865843048352293366,
      64'd9734989958493437952
   };
   localparam logic [DIST_W-1:0] THRESH_RESET = 13'd30;

   // Live configuration seen by the datapath
   typedef struct packed {
      logic [PAL_SLOTS-1:0][COLOR_W-1:0] colors;
      logic [DIST_W-1:0]                 threshold;
      logic                              snap_enable;
   } cfg_type;

   // One palette candidate
   typedef struct packed {
      logic               valid;
      logic [DIST_W-1:0]  sq_dist;
      logic [COLOR_W-1:0] color;
   } cand_type;

endpackage

@@ design/pal_snap_csr.sv @@
`timescale 1ns / 1ps

module pal_snap_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pal_snap_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pal_snap_pkg::CSR_DATA_W-1:0]    csr_data,
   output pal_snap_pkg::cfg_type                  cfg
);
   import pal_snap_pkg::*;

   logic [PAL_WORDS-1:0][CSR_DATA_W-1:0] pal_ff, pal_in;
   logic [DIST_W-1:0]                    thresh_ff, thresh_in;
   logic                                 enable_ff, enable_in;

   // Take every write at once
   assign csr_ready = 1'b1;

   // Decode the write; indexes beyond the list are dropped
   always_comb begin
      pal_in    = pal_ff;
      thresh_in = thresh_ff;
      enable_in = enable_ff;
      if (csr_valid) begin
         unique case (csr_index) inside
            CSR_PAL0, CSR_PAL1, CSR_PAL2, CSR_PAL3: begin
               pal_in[csr_index[1:0]] = csr_data;
            end
            CSR_THRESH: begin
               thresh_in = csr_data[DIST_W-1:0];
            end
            CSR_ENABLE: begin
               enable_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pal_ff    <= PAL_RESET;
         thresh_ff <= THRESH_RESET;
         enable_ff <= 1'b1;
      end else begin
         pal_ff    <= pal_in;
         thresh_ff <= thresh_in;
         enable_ff <= enable_in;
      end
   end

   assign cfg.colors      = pal_ff;
   assign cfg.threshold   = thresh_ff;
   assign cfg.snap_enable = enable_ff;

endmodule

@@ design/pal_snap_dist.sv @@
`timescale 1ns / 1ps

module pal_snap_dist (
   input  logic [pal_snap_pkg::COLOR_W-1:0] pixel,
   input  logic [pal_snap_pkg::COLOR_W-1:0] color,
   input  logic [pal_snap_pkg::DIST_W-1:0]  threshold,
   output pal_snap_pkg::cand_type           cand
);
   import pal_snap_pkg::*;

   function automatic logic [11:0] sq_diff(input logic [5:0] a, input logic [5:0] b);
      logic [5:0]  d;
      logic [11:0] dw;
      d  = (a >= b) ? (a - b) : (b - a);
      dw = {6'b000000, d};
      return dw * dw;
   endfunction

   logic [11:0]       sq_r, sq_g, sq_b;
   logic [DIST_W-1:0] sq_dist;

   // Square each component difference
   assign sq_r = sq_diff({1'b0, pixel[15:11]}, {1'b0, color[15:11]});
   assign sq_g = sq_diff(pixel[10:5], color[10:5]);
   assign sq_b = sq_diff({1'b0, pixel[4:0]}, {1'b0, color[4:0]});

   // Sum and qualify against the threshold
   assign sq_dist      = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
   assign cand.valid   = (sq_dist < threshold);
   assign cand.sq_dist = sq_dist;
   assign cand.color   = color;

endmodule

@@ design/pal_snap_pick.sv @@
`timescale 1ns / 1ps

module pal_snap_pick (
   input  pal_snap_pkg::cand_type cands [pal_snap_pkg::PAL_SLOTS],
   output pal_snap_pkg::cand_type best
);
   import pal_snap_pkg::*;

   // Keep the lower index unless the upper one is strictly nearer
   function automatic cand_type merge(input cand_type lo, input cand_type hi);
      if (hi.valid && (!lo.valid || (hi.sq_dist < lo.sq_dist))) begin
         return hi;
      end
      return lo;
   endfunction

   cand_type lvl1 [8];
   cand_type lvl2 [4];
   cand_type lvl3 [2];

   // Reduce the sixteen candidates in four levels
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         lvl1[i] = merge(cands[2*i], cands[2*i+1]);
      end
      for (int i = 0; i < 4; i++) begin
         lvl2[i] = merge(lvl1[2*i], lvl1[2*i+1]);
      end
      for (int i = 0; i < 2; i++) begin
         lvl3[i] = merge(lvl2[2*i], lvl2[2*i+1]);
      end
      best = merge(lvl3[0], lvl3[1]);
   end

endmodule

@@ design/palette_snap_rgb565_unit.sv @@
`timescale 1ns / 1ps

// Nearest palette color snap for RGB565 pixels.
// Request channel: drive req_pixel_in and raise req_start; the request is
// taken at any rising edge where req_start is high and busy is low. busy
// stays low, so a new pixel may be given every cycle.
// Result channel: rsp_strobe is high for one cycle with rsp_pixel_out and
// rsp_matched; the result is taken at the edge that ends that cycle.
// Pipeline: a taken request is captured in the input register and its
// result in the result register, which drives the result channel.
// Throughput: one pixel per cycle, set by the single pass from the input
// register through sixteen distance lanes and a four level compare tree into the result register.
// Configuration: csr_valid/csr_ready write channel, csr_ready always high;
// index 0..3 palette words, 4 threshold, 5 snap enable, others dropped.
// Write it only while no request is in flight.
// Reset: palette, threshold and enable return to their defaults, and no
// result is pending. The receiver cannot stall: results are not held.
module palette_snap_rgb565_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_start,
   output logic                                 busy,
   input  logic [15:0]                          req_pixel_in,
   output logic                                 rsp_strobe,
   output logic [15:0]                          rsp_pixel_out,
   output logic                                 rsp_matched,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pal_snap_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pal_snap_pkg::CSR_DATA_W-1:0]  csr_data
);
   import pal_snap_pkg::*;

   cfg_type            cfg;
   cand_type           cands [PAL_SLOTS];
   cand_type           best;
   logic               accept;
   logic               hit;
   logic               in_valid_ff;
   logic [COLOR_W-1:0] in_pixel_ff;
   logic               out_valid_ff;
   logic [COLOR_W-1:0] out_pixel_ff, out_pixel_in;
   logic               out_match_ff, out_match_in;

   pal_snap_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Never hold off a request
   assign busy   = 1'b0;
   assign accept = req_start && !busy;

   // One distance lane per active palette entry; spare lanes stay empty
   for (genvar i = 0; i < PAL_SLOTS; i++) begin : g_lane
      if (i < PALETTE_ENTRIES) begin : g_on
         pal_snap_dist u_dist (
            .pixel     (in_pixel_ff),
            .color     (cfg.colors[i]),
            .threshold (cfg.threshold),
            .cand      (cands[i])
         );
      end else begin : g_off
         assign cands[i] = '0;
      end
   end

   pal_snap_pick u_pick (
      .cands (cands),
      .best  (best)
   );

   // Choose the palette color or pass the pixel
   assign hit          = cfg.snap_enable && best.valid;
   assign out_pixel_in = hit ? best.color : in_pixel_ff;
   assign out_match_in = hit;

   // Advance the valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= accept;
         out_valid_ff <= in_valid_ff;
      end
   end

   // Capture the request and the result
   always_ff @(posedge clock) begin
      if (accept) begin
         in_pixel_ff <= req_pixel_in;
      end
      if (in_valid_ff) begin
         out_pixel_ff <= out_pixel_in;
         out_match_ff <= out_match_in;
      end
   end

   assign rsp_strobe    = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;
   assign rsp_matched   = out_match_ff;

`include "palette_snap_rgb565_unit_macros.svh"

   `PSR_ASSERT_LAT2(a_latency, accept, rsp_strobe)
   `PSR_ASSERT(a_pass_unmatched, (rsp_strobe && !rsp_matched) |-> (rsp_pixel_out == $past(req_pixel_in, 2)))
   `PSR_ASSERT(a_off_no_match, (rsp_strobe && !$past(cfg.snap_enable)) |-> !rsp_matched)
   `PSR_ASSERT(a_strobe_source, rsp_strobe |-> $past(in_valid_ff))

endmodule

@@ tb/palette_snap_rgb565_unit_test.sv @@
`timescale 1ns / 1ps

module palette_snap_rgb565_unit_test;
   import pal_snap_pkg::*;

   // Register indexes past the end of the list; writes there are dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_7 = 3'd7;
   localparam int TIMEOUT_CYCLES  = 200000;
   localparam int ITEMS_PER_PHASE = 230;
   localparam int DRAIN_CYCLES    = 4;

   typedef struct {
      logic [COLOR_W-1:0] pixel;
      logic               matched;
   } snap_result_type;

   // Palette snap predictor plus the queue of results still owed by the block
   class snap_scoreboard_type;
      logic [CSR_DATA_W-1:0] pal_words [PAL_WORDS];
      logic [DIST_W-1:0]     threshold;
      logic                  snap_on;
      snap_result_type       snap_q [$];
      int                    mismatches;

      function new();
         for (int w = 0; w < PAL_WORDS; w++) begin
            pal_words[w] = PAL_RESET[w];
         end
         threshold  = THRESH_RESET;
         snap_on    = 1'b1;
         mismatches = 0;
      endfunction

      function logic [COLOR_W-1:0] entry(int i);
         return pal_words[i / 4][(i % 4) * 16 +: 16];
      endfunction

      function int sq_diff(int a, int b);
         int d;
         d = a - b;
         return d * d;
      endfunction

      // Apply a register write the block accepted; drop bits past the width
      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_PAL0, CSR_PAL1, CSR_PAL2, CSR_PAL3: pal_words[idx] = data;
            CSR_THRESH: threshold = data[DIST_W-1:0];
            CSR_ENABLE: snap_on = data[0];
            default: ;
         endcase
      endfunction

      // Nearest entry strictly under threshold, lowest index on a tie
      function snap_result_type nearest(logic [COLOR_W-1:0] px);
         snap_result_type res;
         logic [COLOR_W-1:0] c;
         int best;
         int sq_dist;
         res.pixel   = px;
         res.matched = 1'b0;
         best        = 0;
         if (snap_on) begin
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
               c = entry(i);
               sq_dist = sq_diff(px[15:11], c[15:11]) + sq_diff(px[10:5], c[10:5])
                       + sq_diff(px[4:0], c[4:0]);
               if (sq_dist < int'(threshold) && (!res.matched || sq_dist < best)) begin
                  res.matched = 1'b1;
                  res.pixel   = c;
                  best        = sq_dist;
               end
            end
         end
         return res;
      endfunction

      function void note_request(logic [COLOR_W-1:0] px);
         snap_q.push_back(nearest(px));
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      task check_result(logic [COLOR_W-1:0] px, logic matched);
         snap_result_type exp_res;
         if (snap_q.size() == 0) begin
            report_mismatch($sformatf("result %h/%b with no request pending", px, matched));
         end else begin
            exp_res = snap_q.pop_front();
            if (px !== exp_res.pixel) begin
               report_mismatch($sformatf("pixel_out %h, expected %h", px, exp_res.pixel));
            end
            if (matched !== exp_res.matched) begin
               report_mismatch($sformatf("matched %b, expected %b", matched,
                                         exp_res.matched));
            end
         end
      endtask

      function int pending();
         return snap_q.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_start = 1'b0;
   logic [COLOR_W-1:0]     req_pixel_in = '0;
   logic                   csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   busy;
   logic                   rsp_strobe;
   logic [COLOR_W-1:0]     rsp_pixel_out;
   logic                   rsp_matched;
   logic                   csr_ready;
   int                     cycle_count = 0;

   snap_scoreboard_type sb = new();

   palette_snap_rgb565_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_start     (req_start),
      .busy          (busy),
      .req_pixel_in  (req_pixel_in),
      .rsp_strobe    (rsp_strobe),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_matched   (rsp_matched),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watch every channel at each edge outside reset: check results, note requests and writes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            sb.check_result(rsp_pixel_out, rsp_matched);
         end
         if (req_start && !busy) begin
            sb.note_request(req_pixel_in);
         end
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_data);
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Offer one request, idling first with the given chance in percent
   task automatic send_pixel(input logic [COLOR_W-1:0] px, input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         req_start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_start    <= 1'b1;
      req_pixel_in <= px;
      do @(posedge clock); while (busy);
   endtask

   // Hold off requests until every result is back, then let the pipe settle
   task automatic drain();
      req_start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high so back-to-back writes need one assignment per edge
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic end_csr();
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Pick a random palette word, now and then all zeros or all ones
   function automatic logic [CSR_DATA_W-1:0] rand_pal_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return rand_word();
      endcase
   endfunction

   // Reprogram every register with a random setting, extremes included
   task automatic random_config();
      logic [CSR_DATA_W-1:0] words [PAL_WORDS];
      logic [CSR_DATA_W-1:0] thr;
      for (int w = 0; w < PAL_WORDS; w++) begin
         words[w] = rand_pal_word();
      end
      // Duplicate a word now and then so equal distances show up
      if ($urandom_range(3) == 0) begin
         words[$urandom_range(1, 3)] = words[0];
      end
      thr = rand_word();
      case ($urandom_range(9))
         0: thr[DIST_W-1:0] = '0;
         1: thr[DIST_W-1:0] = '1;
         2: thr[DIST_W-1:0] = 13'd1;
         3: thr[DIST_W-1:0] = 13'($urandom_range(1000, 8191));
         default: thr[DIST_W-1:0] = 13'($urandom_range(1, 300));
      endcase
      write_csr(CSR_PAL0, words[0]);
      write_csr(CSR_PAL1, words[1]);
      write_csr(CSR_PAL2, words[2]);
      write_csr(CSR_PAL3, words[3]);
      write_csr(CSR_THRESH, thr);
      write_csr(CSR_ENABLE, {63'(rand_word()), 1'($urandom_range(7) != 0)});
      if ($urandom_range(3) == 0) begin
         write_csr($urandom_range(1) ? CSR_SPARE_6 : CSR_SPARE_7, rand_word());
      end
      end_csr();
   endtask

   // About half the pixels near a palette entry, the rest anywhere
   function automatic logic [COLOR_W-1:0] rand_pixel();
      logic [COLOR_W-1:0] c;
      if ($urandom_range(1)) begin
         c = sb.entry($urandom_range(PALETTE_ENTRIES - 1));
         return c ^ {3'b000, 2'($urandom), 4'b0000, 2'($urandom), 3'b000, 2'($urandom)};
      end
      return 16'($urandom);
   endfunction

   // Run one idling mode through several random settings
   task automatic random_phase(input int idle_pct);
      int left;
      int chunk;
      left = ITEMS_PER_PHASE;
      while (left > 0) begin
         drain();
         random_config();
         chunk = $urandom_range(20, 60);
         if (chunk > left) chunk = left;
         for (int n = 0; n < chunk; n++) begin
            // Occasionally pause until the block has caught up
            if ($urandom_range(49) == 0) drain();
            send_pixel(rand_pixel(), idle_pct);
         end
         left -= chunk;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset palette: exact hits, near misses, field extremes
      send_pixel(16'h0000, 17);
      send_pixel(16'hffff, 17);
      send_pixel(16'ha1c9, 17);
      send_pixel(16'h8719, 17);
      send_pixel(16'h0821, 17);
      send_pixel(16'h1000, 17);
      send_pixel(16'h5555, 17);
      send_pixel(16'haaaa, 17);
      send_pixel(16'hffde, 17);

      // Threshold of zero matches nothing; high data bits are dropped
      drain();
      write_csr(CSR_THRESH, 64'hffff_ffff_ffff_e000);
      end_csr();
      send_pixel(16'h0000, 17);
      send_pixel(16'hffff, 17);

      // Snapping off with the widest threshold; stray writes past the list
      drain();
      write_csr(CSR_THRESH, 64'h1fff);
      write_csr(CSR_ENABLE, 64'hffff_ffff_ffff_fffe);
      write_csr(CSR_SPARE_6, 64'h0123_4567_89ab_cdef);
      write_csr(CSR_SPARE_7, '1);
      end_csr();
      send_pixel(16'h0000, 17);
      send_pixel(16'ha1c9, 17);
      send_pixel(16'h7bef, 17);

      // Equal distances: entries one red step either side of the pixel
      drain();
      write_csr(CSR_PAL0, 64'h4800_ffff_5800_ffff);
      write_csr(CSR_PAL1, '1);
      write_csr(CSR_PAL2, '1);
      write_csr(CSR_PAL3, '1);
      write_csr(CSR_ENABLE, 64'h1);
      end_csr();
      send_pixel(16'h5000, 17);
      send_pixel(16'h4800, 17);
      send_pixel(16'h0000, 17);

      // Every entry identical, threshold of one: only exact hits snap
      drain();
      write_csr(CSR_PAL0, 64'h1234_1234_1234_1234);
      write_csr(CSR_PAL1, 64'h1234_1234_1234_1234);
      write_csr(CSR_PAL2, 64'h1234_1234_1234_1234);
      write_csr(CSR_PAL3, 64'h1234_1234_1234_1234);
      write_csr(CSR_THRESH, 64'h1);
      end_csr();
      send_pixel(16'h1234, 17);
      send_pixel(16'h1235, 17);

      random_phase(17);
      random_phase(68);
      random_phase(0);

      drain();
      if (sb.pending() != 0) begin
         sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
      end
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ palette_snap_rgb565_unit.f @@
+incdir+design
design/pal_snap_pkg.sv
design/pal_snap_csr.sv
design/pal_snap_dist.sv
design/pal_snap_pick.sv
design/palette_snap_rgb565_unit.sv
tb/palette_snap_rgb565_unit_test.sv
